/* hw/rtl/circle_box_collision_resolve_macros.svh */
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CIRCLE_BOX_COLLISION_RESOLVE_MACROS_SVH
`define CIRCLE_BOX_COLLISION_RESOLVE_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define CBCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds while reset is high.
`define CBCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cbcr_pkg.sv */
package cbcr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 4;
  localparam int SIZE_W      = COORD_WIDTH - 1;   // diameter, width, height
  localparam int Q5_W        = COORD_WIDTH + 1;   // doubled coordinates
  localparam int EDGE_W      = COORD_WIDTH + 2;   // box edges and clamped point
  localparam int D_W         = COORD_WIDTH + 3;   // offset to the clamped point
  localparam int SQ_W        = 2 * D_W;           // square of that offset
  localparam int DIST_W      = SQ_W + 1;          // sum of two squares
  localparam int RADSQ_W     = 2 * SIZE_W;        // squared radius
  localparam int BC_W        = Q5_W;              // ball minus box centre
  localparam int BCSQ_W      = 2 * BC_W;
  localparam int NUM_W       = D_W + SIZE_W + 1;  // offset times radius
  localparam int S_W         = RADSQ_W;           // squared length to normalize
  localparam int ROOT_FRAC   = 8;                 // extra fraction bits of the root
  localparam int ROOT_W      = 24;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_PER    = 2;                 // root bits resolved per stage
  localparam int SQRT_STAGES = ROOT_W / SQRT_PER;
  localparam int MAG_W       = S_W;               // numerator magnitude
  localparam int DIVD_W      = MAG_W + ROOT_FRAC + 1;
  localparam int Q_W         = 16;
  localparam int DIV_PER     = 2;                 // quotient bits per stage
  localparam int DIV_STAGES  = Q_W / DIV_PER;
  localparam int SUM_W       = EDGE_W + 2;
  localparam int SAT_HI      = 2 ** (COORD_WIDTH - 1) - 1;
  localparam int SAT_LO      = -(2 ** (COORD_WIDTH - 1));

  // Everything that rides along with an item through the root and divide pipes.
  typedef struct packed {
    logic                     hit;
    logic                     usediv;  // offset comes from the normalized vector
    logic                     neg;     // subtract the offset from the base point
    logic                     sx;
    logic                     sy;
    logic [MAG_W-1:0]         magx;
    logic [MAG_W-1:0]         magy;
    logic signed [EDGE_W-1:0] basex;
    logic signed [EDGE_W-1:0] basey;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [Q_W-1:0]    q;
  } dv_t;

  // One digit of the restoring square root: brings in two radicand bits.
  function automatic sq_t sqrt_step(sq_t a, logic [1:0] pair);
    logic [REM_W+1:0] r;
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] diff;
    sq_t              o;
    r    = {a.rem, pair};
    t    = {2'b00, a.root, 2'b01};
    diff = r - t;
    if (r >= t) begin
      o.rem  = diff[REM_W-1:0];
      o.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r[REM_W-1:0];
      o.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit of the restoring divide, most significant bit first.
  function automatic dv_t div_step(dv_t a, logic [ROOT_W-1:0] len, int unsigned sh);
    logic [DIVD_W-1:0] d;
    dv_t               o;
    d     = DIVD_W'(len) << sh;
    o.q   = {a.q[Q_W-2:0], 1'b0};
    o.rem = a.rem;
    if (a.rem >= d) begin
      o.rem  = a.rem - d;
      o.q[0] = 1'b1;
    end
    return o;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(SAT_HI);
    lo = SUM_W'(SAT_LO);
    if (v > hi) begin
      return COORD_WIDTH'(SAT_HI);
    end else if (v < lo) begin
      return COORD_WIDTH'(SAT_LO);
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

/* hw/rtl/cbcr_isqrt.sv */
module cbcr_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbcr_pkg::S_W-1:0]      radicand,
  input  cbcr_pkg::side_t               in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbcr_pkg::ROOT_W-1:0]   root,
  output cbcr_pkg::side_t               out_side
);
  import cbcr_pkg::*;

  logic [SQRT_STAGES-1:0] vld;
  logic [SQRT_STAGES-1:0] vin;
  logic [SQRT_STAGES:0]   en;
  sq_t                    st  [SQRT_STAGES];
  logic [RAD_W-1:0]       rad [SQRT_STAGES];
  side_t                  sd  [SQRT_STAGES];

  assign en[SQRT_STAGES] = out_ready;
  assign in_ready        = en[0];
  assign vin             = {vld[SQRT_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    sq_t              a_prev;
    logic [RAD_W-1:0] r_prev;
    side_t            s_prev;
    sq_t              a_next;
    logic [RAD_W-1:0] r_next;

    assign en[k] = !vld[k] || en[k+1];

    if (k == 0) begin : g_first
      assign a_prev = '0;
      assign r_prev = {(RAD_W - S_W - 2 * ROOT_FRAC)'(0), radicand, (2 * ROOT_FRAC)'(0)};
      assign s_prev = in_side;
    end else begin : g_rest
      assign a_prev = st[k-1];
      assign r_prev = rad[k-1];
      assign s_prev = sd[k-1];
    end

    always_comb begin
      a_next = a_prev;
      r_next = r_prev;
      for (int i = 0; i < SQRT_PER; i++) begin
        a_next = sqrt_step(a_next, r_next[RAD_W-1 -: 2]);
        r_next = r_next << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k]  <= a_next;
        rad[k] <= r_next;
        sd[k]  <= s_prev;
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign root      = st[SQRT_STAGES-1].root;
  assign out_side  = sd[SQRT_STAGES-1];

endmodule

/* hw/rtl/cbcr_div.sv */
module cbcr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cbcr_pkg::ROOT_W-1:0]   len,
  input  cbcr_pkg::side_t               in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cbcr_pkg::Q_W-1:0]      qx,
  output logic [cbcr_pkg::Q_W-1:0]      qy,
  output cbcr_pkg::side_t               out_side
);
  import cbcr_pkg::*;

  localparam int NST = DIV_STAGES + 1;

  logic [NST-1:0]    vld;
  logic [NST-1:0]    vin;
  logic [NST:0]      en;
  dv_t               dx  [NST];
  dv_t               dy  [NST];
  logic [ROOT_W-1:0] lens[NST];
  side_t             sd  [NST];

  assign en[NST]  = out_ready;
  assign in_ready = en[0];
  assign vin      = {vld[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vin[k];
        end
      end
    end
  end

  // First stage forms the rounded dividend: magnitude scaled by the root's
  // fraction bits plus half the divisor.
  assign en[0] = !vld[0] || en[1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx[0].rem <= DIVD_W'({in_side.magx, ROOT_FRAC'(0)}) + DIVD_W'(len >> 1);
      dy[0].rem <= DIVD_W'({in_side.magy, ROOT_FRAC'(0)}) + DIVD_W'(len >> 1);
      dx[0].q   <= '0;
      dy[0].q   <= '0;
      lens[0]   <= len;
      sd[0]     <= in_side;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_stage
    dv_t ax;
    dv_t ay;

    assign en[k] = !vld[k] || en[k+1];

    always_comb begin
      ax = dx[k-1];
      ay = dy[k-1];
      for (int i = 0; i < DIV_PER; i++) begin
        ax = div_step(ax, lens[k-1], (Q_W - 1 - DIV_PER * (k - 1) - i));
        ay = div_step(ay, lens[k-1], (Q_W - 1 - DIV_PER * (k - 1) - i));
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        dx[k]   <= ax;
        dy[k]   <= ay;
        lens[k] <= lens[k-1];
        sd[k]   <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign qx        = dx[NST-1].q;
  assign qy        = dy[NST-1].q;
  assign out_side  = sd[NST-1];

endmodule

/* hw/rtl/circle_box_collision_resolve.sv */
// Channel   Direction  Handshake            Payload
// in        to block   in_valid / in_stall  ball_x, ball_y, ball_diameter,
//                                           box_centre_x, box_centre_y,
//                                           box_width, box_height
// out       from block out_valid / out_stall collided, new_ball_x, new_ball_y
// cfg       to block   cfg_valid / cfg_ready cfg_data (up_is_negative_y)
//
// One item enters per clock and one result leaves per clock when nothing stalls.
// The pipe has four geometry stages, twelve root stages (two root bits
// each), nine divide stages (dividend setup, then two quotient bits each) and
// the output register. Reset is synchronous and empties every stage; the
// configuration register returns to up being minus y. A stall on the output
// holds the result in place while bubbles further up still close, so in_stall
// rises only once every stage holds an item.
module circle_box_collision_resolve (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  ball_x,
  input  logic signed [15:0]  ball_y,
  input  logic        [14:0]  ball_diameter,
  input  logic signed [15:0]  box_centre_x,
  input  logic signed [15:0]  box_centre_y,
  input  logic        [14:0]  box_width,
  input  logic        [14:0]  box_height,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                collided,
  output logic signed [15:0]  new_ball_x,
  output logic signed [15:0]  new_ball_y,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import cbcr_pkg::*;

  // Configuration register: the user writes only with the pipe empty; not enforced.
  logic up_is_negative_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_is_negative_y <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      up_is_negative_y <= cfg_data;
    end
  end

  // Stage handshake. A stage loads whenever it is empty or its successor
  // loads, so bubbles collapse under an output stall.
  logic [3:0] vld;
  logic [3:0] vin;
  logic [3:0] en;
  logic       out_en;
  logic       sq_in_ready;
  logic       sq_out_valid;
  logic       dv_in_ready;
  logic       dv_out_valid;

  assign out_en   = !out_valid || !out_stall;
  assign en[3]    = !vld[3] || sq_in_ready;
  assign en[2]    = !vld[2] || en[3];
  assign en[1]    = !vld[1] || en[2];
  assign en[0]    = !vld[0] || en[1];
  assign in_stall = !en[0];
  assign vin      = {vld[2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (en[k]) begin
          vld[k] <= vin[k];
        end
      end
      if (out_en) begin
        out_valid <= dv_out_valid;
      end
    end
  end

  // Stage 0: move to doubled units (one extra fraction bit) so that half
  // sizes are exact, and form the four box edges.
  logic signed [Q5_W-1:0]   s0_b2x, s0_b2y;
  logic signed [EDGE_W-1:0] s0_lx, s0_rx, s0_ly, s0_ry;
  logic signed [BC_W-1:0]   s0_bcx, s0_bcy;
  logic        [SIZE_W-1:0] s0_h, s0_size;
  logic                     s0_eqc;

  logic signed [Q5_W-1:0]   cx2, cy2;
  assign cx2 = {box_centre_x, 1'b0};
  assign cy2 = {box_centre_y, 1'b0};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_b2x  <= {ball_x, 1'b0};
      s0_b2y  <= {ball_y, 1'b0};
      s0_lx   <= EDGE_W'(cx2) - EDGE_W'(box_width);
      s0_rx   <= EDGE_W'(cx2) + EDGE_W'(box_width);
      s0_ly   <= EDGE_W'(cy2) - EDGE_W'(box_height);
      s0_ry   <= EDGE_W'(cy2) + EDGE_W'(box_height);
      s0_bcx  <= BC_W'(ball_x) - BC_W'(box_centre_x);
      s0_bcy  <= BC_W'(ball_y) - BC_W'(box_centre_y);
      s0_h    <= box_height;
      s0_size <= ball_diameter;
      s0_eqc  <= (ball_x == box_centre_x) && (ball_y == box_centre_y);
    end
  end

  // Stage 1: clamp the ball centre into the box to get the closest point,
  // and the vector from the centre to it.
  logic signed [EDGE_W-1:0] px_n, py_n;
  logic signed [EDGE_W-1:0] s1_px, s1_py;
  logic signed [D_W-1:0]    s1_dx, s1_dy;
  logic signed [Q5_W-1:0]   s1_b2x, s1_b2y;
  logic signed [BC_W-1:0]   s1_bcx, s1_bcy;
  logic        [SIZE_W-1:0] s1_h, s1_size;
  logic                     s1_eqc;

  always_comb begin
    if (s0_b2x < s0_lx) begin
      px_n = s0_lx;
    end else if (s0_b2x > s0_rx) begin
      px_n = s0_rx;
    end else begin
      px_n = EDGE_W'(s0_b2x);
    end
    if (s0_b2y < s0_ly) begin
      py_n = s0_ly;
    end else if (s0_b2y > s0_ry) begin
      py_n = s0_ry;
    end else begin
      py_n = EDGE_W'(s0_b2y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_px   <= px_n;
      s1_py   <= py_n;
      s1_dx   <= D_W'(px_n) - D_W'(s0_b2x);
      s1_dy   <= D_W'(py_n) - D_W'(s0_b2y);
      s1_b2x  <= s0_b2x;
      s1_b2y  <= s0_b2y;
      s1_bcx  <= s0_bcx;
      s1_bcy  <= s0_bcy;
      s1_h    <= s0_h;
      s1_size <= s0_size;
      s1_eqc  <= s0_eqc;
    end
  end

  // Stage 2: all products in parallel. The squared offset gives the hit test
  // and the root's input for the edge case; the centre offsets give the root's
  // input for a ball whose centre sits inside the box.
  logic signed [SQ_W-1:0]    pdxx, pdyy;
  logic signed [BCSQ_W-1:0]  pbcxx, pbcyy;
  logic signed [NUM_W-1:0]   pnex, pney;
  logic        [RADSQ_W-1:0] pradsq;
  logic signed [SIZE_W:0]    size_s;

  assign size_s = {1'b0, s1_size};
  assign pdxx   = s1_dx * s1_dx;
  assign pdyy   = s1_dy * s1_dy;
  assign pbcxx  = s1_bcx * s1_bcx;
  assign pbcyy  = s1_bcy * s1_bcy;
  assign pnex   = s1_dx * size_s;
  assign pney   = s1_dy * size_s;
  assign pradsq = s1_size * s1_size;

  logic        [SQ_W-1:0]    s2_dxx, s2_dyy;
  logic        [BCSQ_W-1:0]  s2_bcxx, s2_bcyy;
  logic signed [NUM_W-1:0]   s2_nex, s2_ney;
  logic        [RADSQ_W-1:0] s2_radsq;
  logic signed [EDGE_W-1:0]  s2_px, s2_py;
  logic signed [Q5_W-1:0]    s2_b2x, s2_b2y;
  logic signed [BC_W-1:0]    s2_bcx, s2_bcy;
  logic        [SIZE_W-1:0]  s2_h, s2_size;
  logic                      s2_eqc, s2_dzero;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_dxx   <= pdxx;
      s2_dyy   <= pdyy;
      s2_bcxx  <= pbcxx;
      s2_bcyy  <= pbcyy;
      s2_nex   <= pnex;
      s2_ney   <= pney;
      s2_radsq <= pradsq;
      s2_px    <= s1_px;
      s2_py    <= s1_py;
      s2_b2x   <= s1_b2x;
      s2_b2y   <= s1_b2y;
      s2_bcx   <= s1_bcx;
      s2_bcy   <= s1_bcy;
      s2_h     <= s1_h;
      s2_size  <= s1_size;
      s2_eqc   <= s1_eqc;
      s2_dzero <= (s1_dx == '0) && (s1_dy == '0);
    end
  end

  // Stage 3: hit test and choice of how the ball is pushed out. The final
  // position is a base point plus or minus a normalized offset, so only the
  // base, the flags and signs, the numerator magnitudes and the squared length travel on.
  logic        [DIST_W-1:0] dist_sq;
  logic                     hit;
  logic signed [NUM_W-1:0]  anex, aney;
  logic signed [BC_W-1:0]   abcx, abcy;
  logic signed [EDGE_W-1:0] hs;
  logic signed [EDGE_W-1:0] b2y_e;
  side_t                    side_n;
  logic        [S_W-1:0]    rad_n;
  side_t                    s3_side;
  logic        [S_W-1:0]    s3_rad;

  always_comb begin
    dist_sq = {1'b0, s2_dxx} + {1'b0, s2_dyy};
    hit     = dist_sq < DIST_W'(s2_radsq);
    anex    = (s2_nex < 0) ? -s2_nex : s2_nex;
    aney    = (s2_ney < 0) ? -s2_ney : s2_ney;
    abcx    = (s2_bcx < 0) ? -s2_bcx : s2_bcx;
    abcy    = (s2_bcy < 0) ? -s2_bcy : s2_bcy;
    hs      = EDGE_W'(s2_h) + EDGE_W'(s2_size);
    b2y_e   = EDGE_W'(s2_b2y);
    side_n  = '0;
    rad_n   = '0;
    side_n.hit   = hit;
    side_n.basex = EDGE_W'(s2_b2x);
    side_n.basey = b2y_e;
    if (hit) begin
      if (!s2_dzero) begin
        // Centre outside the box: step back from the closest point by the
        // radius along the offset direction.
        side_n.usediv = 1'b1;
        side_n.neg    = 1'b1;
        side_n.sx     = s2_nex[NUM_W-1];
        side_n.sy     = s2_ney[NUM_W-1];
        side_n.magx   = anex[MAG_W-1:0];
        side_n.magy   = aney[MAG_W-1:0];
        side_n.basex  = s2_px;
        side_n.basey  = s2_py;
        rad_n         = dist_sq[S_W-1:0];
      end else if (s2_eqc) begin
        // Centres coincide: push straight up by half the height plus radius.
        side_n.basey = up_is_negative_y ? (b2y_e - hs) : (b2y_e + hs);
      end else begin
        // Centre inside the box: move one unit away from the box centre.
        side_n.usediv = 1'b1;
        side_n.sx     = s2_bcx[BC_W-1];
        side_n.sy     = s2_bcy[BC_W-1];
        side_n.magx   = MAG_W'(abcx) << (FRAC_BITS + 1);
        side_n.magy   = MAG_W'(abcy) << (FRAC_BITS + 1);
        rad_n         = S_W'(s2_bcxx + s2_bcyy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_side <= side_n;
      s3_rad  <= rad_n;
    end
  end

  // Length of the offset vector with eight fraction bits, then the two
  // rounded divisions that give the scaled unit vector.
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;
  logic [Q_W-1:0]    dv_qx, dv_qy;
  side_t             dv_side;

  cbcr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[3]),
    .in_ready  (sq_in_ready),
    .radicand  (s3_rad),
    .in_side   (s3_side),
    .out_valid (sq_out_valid),
    .out_ready (dv_in_ready),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  cbcr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_out_valid),
    .in_ready  (dv_in_ready),
    .len       (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_out_valid),
    .out_ready (out_en),
    .qx        (dv_qx),
    .qy        (dv_qy),
    .out_side  (dv_side)
  );

  // Output stage: apply the signed offset, go back to Q12.4 by rounding half
  // toward plus infinity, and saturate.
  logic signed [SUM_W-1:0] qxs, qys;
  logic signed [SUM_W-1:0] vx, vy;
  logic signed [SUM_W-1:0] hx, hy;

  always_comb begin
    qxs = dv_side.usediv ? SUM_W'(dv_qx) : '0;
    qys = dv_side.usediv ? SUM_W'(dv_qy) : '0;
    vx  = SUM_W'(dv_side.basex) + ((dv_side.sx ^ dv_side.neg) ? -qxs : qxs);
    vy  = SUM_W'(dv_side.basey) + ((dv_side.sy ^ dv_side.neg) ? -qys : qys);
    hx  = (vx + SUM_W'(1)) >>> 1;
    hy  = (vy + SUM_W'(1)) >>> 1;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      collided   <= dv_side.hit;
      new_ball_x <= sat_coord(hx);
      new_ball_y <= sat_coord(hy);
    end
  end

endmodule

/* hw/rtl/cbcr_checker.sv */
`include "circle_box_collision_resolve_macros.svh"

module cbcr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               collided,
  input logic signed [15:0] new_ball_x,
  input logic signed [15:0] new_ball_y,
  input logic               cfg_ready
);

  // A result item that is held back stays offered.
  `CBCR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result item dropped under stall")

  // A result item that is held back keeps its value.
  `CBCR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(new_ball_x) && $stable(new_ball_y) && $stable(collided), "result item changed under stall")

  // With room at the output the whole pipe moves, so the input never waits.
  `CBCR_ASSERT(a_no_block, !out_valid || !out_stall |-> !in_stall, "input stalled with room at the output")

  // Configuration writes are always taken.
  `CBCR_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

  // Reset empties the pipe.
  `CBCR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result item offered after reset")

endmodule

bind circle_box_collision_resolve cbcr_checker u_cbcr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .collided   (collided),
  .new_ball_x (new_ball_x),
  .new_ball_y (new_ball_y),
  .cfg_ready  (cfg_ready)
);
